>>> rtl/core/flrl_pkg.sv
// Package for the fault latch, retry and lockout manager.
// Holds the command and recovery mode codes, register indexes and word types.
// No dependencies.
package flrl_pkg;

   // Default number of managed faults
   localparam int FAULT_COUNT_DEFAULT = 8;

   // Faults that own a field in the mode and limit registers
   localparam int REG_FAULTS = 8;

   // Width of each reported bitmask
   localparam int FLAG_WIDTH = 8;

   localparam int ID_WIDTH    = 5;
   localparam int COUNT_WIDTH = 8;
   localparam int LIMIT_WIDTH = 4;
   localparam int MODE_WIDTH  = 2;
   localparam int MODES_WIDTH = 16;
   localparam int CSR_WIDTH   = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [1:0] {
      CMD_SET       = 2'd0,
      CMD_CLEAR     = 2'd1,
      CMD_CLEAR_ALL = 2'd2,
      CMD_SILENT    = 2'd3
   } command_type;

   typedef enum logic [MODE_WIDTH-1:0] {
      MODE_NONE      = 2'd0,
      MODE_UNLIMITED = 2'd1,
      MODE_LIMITED   = 2'd2,
      MODE_RESERVED  = 2'd3
   } mode_type;

   typedef enum logic {
      CSR_RECOVERY_MODES = 1'b0,
      CSR_RETRY_LIMITS   = 1'b1
   } csr_index_type;

   typedef struct packed {
      command_type         command;
      logic [ID_WIDTH-1:0] fault_id;
   } req_word_type;

   typedef struct packed {
      logic [FLAG_WIDTH-1:0] latched_flags;
      logic [FLAG_WIDTH-1:0] active_flags;
      logic [FLAG_WIDTH-1:0] locked_flags;
      logic                  any_latched;
   } rsp_word_type;

endpackage

>>> rtl/core/fault_latch_retry_lockout.sv
// Top level of the fault latch, retry and lockout manager.
// Uses flrl_pkg for codes and word types; no submodules.
//
// Usage:
//   req channel: one command word (command, fault_id) per handshake. Set, clear
//   with recovery, clear all and silent clear act on per-fault active, latched
//   and lockout bits and an 8-bit saturating retry counter per fault.
//   rsp channel: one word per command with the latched, active and locked
//   bitmasks (faults 0 to 7) and an any-latched flag over every fault.
//   csr channel: index 0 writes the recovery modes (2 bits per fault), index 1
//   the retry limits (4 bits per fault). Always ready; write only while idle.
// Timing and throughput:
//   The state update and the response word are computed in the accepting cycle
//   and the output register presents the response in the next cycle. With
//   rsp_ready high, one command per cycle is sustained, set by that register.
// Reset:
//   Clears all fault state, both configuration registers (every mode none,
//   every limit zero) and the response valid flag.
// Stall:
//   While a response waits with rsp_ready low, req_ready drops; a waiting
//   response that is taken lets a new command in during the same cycle.
module fault_latch_retry_lockout #(
   parameter int FAULT_COUNT = flrl_pkg::FAULT_COUNT_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  flrl_pkg::req_word_type     req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output flrl_pkg::rsp_word_type     rsp_word,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  flrl_pkg::csr_index_type    csr_index,
   input  logic [flrl_pkg::CSR_WIDTH-1:0] csr_wdata
);
   import flrl_pkg::*;

   logic [MODES_WIDTH-1:0] recovery_modes_ff;
   logic [CSR_WIDTH-1:0]   retry_limits_ff;

   logic [FAULT_COUNT-1:0] active_ff, active_in;
   logic [FAULT_COUNT-1:0] latched_ff, latched_in;
   logic [FAULT_COUNT-1:0] lockout_ff, lockout_in;
   logic [COUNT_WIDTH-1:0] retry_count_ff [FAULT_COUNT];
   logic [COUNT_WIDTH-1:0] retry_count_in [FAULT_COUNT];

   logic                   rsp_valid_ff;
   rsp_word_type           rsp_word_ff, rsp_word_in;
   logic                   req_accept;

   logic [FLAG_WIDTH-1:0]  latched_flags, active_flags, locked_flags;

   // Handshakes
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         recovery_modes_ff <= '0;
         retry_limits_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RECOVERY_MODES: recovery_modes_ff <= csr_wdata[MODES_WIDTH-1:0];
            CSR_RETRY_LIMITS:   retry_limits_ff   <= csr_wdata;
            default:            ;
         endcase
      end
   end

   // Per-fault lane: next state of one fault for the incoming command
   for (genvar i = 0; i < FAULT_COUNT; i++) begin : g_fault
      mode_type               mode;
      logic [LIMIT_WIDTH-1:0] limit;
      logic                   hit;
      logic [COUNT_WIDTH-1:0] count_inc;

      // Faults past the register fields read mode none and limit zero
      if (i < REG_FAULTS) begin : g_field
         assign mode  = mode_type'(recovery_modes_ff[MODE_WIDTH*i +: MODE_WIDTH]);
         assign limit = retry_limits_ff[LIMIT_WIDTH*i +: LIMIT_WIDTH];
      end else begin : g_nofield
         assign mode  = MODE_NONE;
         assign limit = '0;
      end

      assign hit       = (req_word.fault_id == ID_WIDTH'(i));
      assign count_inc = (retry_count_ff[i] == COUNT_MAX) ? retry_count_ff[i]
                                                         : retry_count_ff[i] + 1'b1;

      always_comb begin
         active_in[i]      = active_ff[i];
         latched_in[i]     = latched_ff[i];
         lockout_in[i]     = lockout_ff[i];
         retry_count_in[i] = retry_count_ff[i];
         case (req_word.command)
            CMD_SET: begin
               if (hit) begin
                  active_in[i]  = 1'b1;
                  latched_in[i] = 1'b1;
               end
            end
            CMD_SILENT: begin
               if (hit) begin
                  active_in[i]  = 1'b0;
                  latched_in[i] = 1'b0;
               end
            end
            CMD_CLEAR_ALL: begin
               if (!lockout_ff[i]) begin
                  latched_in[i]     = 1'b0;
                  retry_count_in[i] = '0;
               end
            end
            CMD_CLEAR: begin
               if (hit) begin
                  active_in[i] = 1'b0;
                  if (!lockout_ff[i]) begin
                     case (mode)
                        MODE_UNLIMITED: begin
                           retry_count_in[i] = count_inc;
                           latched_in[i]     = 1'b0;
                        end
                        MODE_LIMITED: begin
                           retry_count_in[i] = count_inc;
                           // Lock out once the count passes the limit
                           if (count_inc > COUNT_WIDTH'(limit)) begin
                              lockout_in[i] = 1'b1;
                           end else begin
                              latched_in[i] = 1'b0;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // Report only the low faults in the bitmasks
   for (genvar j = 0; j < FLAG_WIDTH; j++) begin : g_flag
      if (j < FAULT_COUNT) begin : g_live
         assign latched_flags[j] = latched_in[j];
         assign active_flags[j]  = active_in[j];
         assign locked_flags[j]  = lockout_in[j];
      end else begin : g_absent
         assign latched_flags[j] = 1'b0;
         assign active_flags[j]  = 1'b0;
         assign locked_flags[j]  = 1'b0;
      end
   end

   always_comb begin
      rsp_word_in.latched_flags = latched_flags;
      rsp_word_in.active_flags  = active_flags;
      rsp_word_in.locked_flags  = locked_flags;
      rsp_word_in.any_latched   = |latched_in;
   end

   // Fault state: advance on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff  <= '0;
         latched_ff <= '0;
         lockout_ff <= '0;
         for (int k = 0; k < FAULT_COUNT; k++) begin
            retry_count_ff[k] <= '0;
         end
      end else if (req_accept) begin
         active_ff  <= active_in;
         latched_ff <= latched_in;
         lockout_ff <= lockout_in;
         for (int k = 0; k < FAULT_COUNT; k++) begin
            retry_count_ff[k] <= retry_count_in[k];
         end
      end
   end

   // Response register: load on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // A lockout bit is only ever cleared by reset
   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> ((lockout_ff & $past(lockout_ff)) == $past(lockout_ff)))
      else $error("lockout bit cleared without reset");

   // A waiting response's any-latched flag always matches the held latched state
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_word_ff.any_latched == (|latched_ff)))
      else $error("response any_latched disagrees with latched state");

   // Latched and active state move only when a word is accepted
   assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> ($stable(latched_ff) && $stable(active_ff)))
      else $error("fault state changed without an accepted word");

endmodule
